>>> sv/atb_pkg.sv
`timescale 1ns / 1ps
// Package for the ATA task-file builder: item structs, status and mode codes,
// ATA command bytes and the divide-by-63 reciprocal. No dependencies.
package atb_pkg;

  // Configuration port widths
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned FLAGS_W     = 20;
  localparam int unsigned FLAG_BITS   = 5;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_FLAGS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECTORS0    = 3'd1;

  // Flag bit positions inside one drive's group
  localparam int unsigned FLAG_PRESENT = 0;
  localparam int unsigned FLAG_ATA     = 1;
  localparam int unsigned FLAG_LBA     = 2;
  localparam int unsigned FLAG_SLAVE   = 3;
  localparam int unsigned FLAG_CHANNEL = 4;

  // Status codes
  localparam logic [1:0] ST_ISSUED    = 2'd0;
  localparam logic [1:0] ST_NO_DRIVE  = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NON_ATA   = 2'd3;

  // Address modes
  localparam logic [1:0] MODE_CHS   = 2'd0;
  localparam logic [1:0] MODE_LBA28 = 2'd1;
  localparam logic [1:0] MODE_LBA48 = 2'd2;

  // Device select bases
  localparam logic [7:0] DEVSEL_CHS = 8'hA0;
  localparam logic [7:0] DEVSEL_LBA = 8'hE0;

  // ATA commands
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
  localparam logic [7:0] CMD_FLUSH     = 8'hE7;
  localparam logic [7:0] CMD_FLUSH_EXT = 8'hEA;
  localparam logic [7:0] CMD_NONE      = 8'h00;

  // x / 63 for x below 2^28: floor(x * RECIP63 / 2^34), exact over that range
  localparam int unsigned LBA28_W   = 28;
  localparam int unsigned RECIP_W   = 29;
  localparam int unsigned PROD_W    = LBA28_W + RECIP_W;
  localparam int unsigned RECIP_SH  = 34;
  localparam int unsigned QUOT_W    = 22;
  localparam logic [RECIP_W-1:0] RECIP63 = 29'd272696337;
  localparam logic [7:0] SECTORS_PER_TRACK = 8'd63;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  drive_index;
    logic [31:0] block_address;
    logic [7:0]  sector_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       channel_select;
    logic [1:0] address_mode;
    logic [7:0] device_select;
    logic [7:0] count_byte;
    logic [7:0] addr_byte0;
    logic [7:0] addr_byte1;
    logic [7:0] addr_byte2;
    logic [7:0] addr_byte3;
    logic [7:0] command_code;
    logic [7:0] flush_code;
  } out_item_t;

endpackage

>>> sv/ata_taskfile_builder_unit.sv
`timescale 1ns / 1ps
// ATA task-file builder: checks one sector request and builds its task-file.
// Depends on atb_pkg for item structs, codes and the divide-by-63 constant.
//
// Usage:
//   Requests enter on in_valid_i / in_stall_o / in_item_i; an item is taken at
//   a rising edge with in_valid_i high and in_stall_o low. Results leave on
//   out_valid_o / out_stall_i / out_item_o, one result per request, in order.
//   The drive table is written through cfg_we_i / cfg_index_i / cfg_data_i
//   while no request is in flight: index 0 holds the drive flags, indexes 1 to
//   DRIVE_COUNT the drive sizes in sectors.
//   out_valid_o rises once an item reaches the output stage register; one
//   item per cycle is sustained while the receiver does not stall. Stage one
//   does the lookup and the 33-bit range compare, stage two the 28 by 29 bit
//   reciprocal multiply for the CHS divide by 63, stage three the remainder
//   and the task-file bytes.
//   When the receiver stalls, the output stage holds its item and the earlier
//   stages keep filling until each holds an item; only then is in_stall_o
//   raised. Nothing is lost or repeated.
//   Reset clears all stage valid bits and the drive table to zero.
module ata_taskfile_builder_unit #(
  parameter int unsigned DRIVE_COUNT = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [atb_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [atb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  atb_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output atb_pkg::out_item_t                  out_item_o
);
  import atb_pkg::*;

  localparam int unsigned DRV_W = (DRIVE_COUNT > 1) ? $clog2(DRIVE_COUNT) : 1;

  // Drive table
  logic [FLAGS_W-1:0] flags_q;
  logic [31:0]        sectors_q [DRIVE_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (cfg_we_i && cfg_index_i == REG_DRIVE_FLAGS) begin
      flags_q <= cfg_data_i[FLAGS_W-1:0];
    end
  end

  for (genvar d = 0; d < DRIVE_COUNT; d++) begin : g_size
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sectors_q[d] <= '0;
      end else if (cfg_we_i &&
                   cfg_index_i == REG_SECTORS0 + CFG_INDEX_W'(d)) begin
        sectors_q[d] <= cfg_data_i;
      end
    end
  end

  // Handshake: a stage advances when the one after it is empty or advancing
  logic va_q, vb_q, vc_q;
  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c      = !vc_q || !out_stall_i;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign in_stall_o = !rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  // Stage A: look up the drive, check it and pick the address mode
  logic [FLAG_BITS-1:0] drv_flags;
  logic [31:0]          drv_size;
  logic                 drv_ok;
  logic [32:0]          end_addr;
  logic [1:0]           status_d;
  logic [1:0]           mode_d;

  always_comb begin
    drv_flags = '0;
    drv_size  = '0;
    drv_ok    = 1'b0;
    for (int d = 0; d < DRIVE_COUNT; d++) begin
      if (in_item_i.drive_index == 8'(d)) begin
        drv_ok    = 1'b1;
        drv_flags = flags_q[FLAG_BITS*d +: FLAG_BITS];
        drv_size  = sectors_q[DRV_W'(d)];
      end
    end
    end_addr = {1'b0, in_item_i.block_address} + {25'd0, in_item_i.sector_count};
    if (!drv_ok || !drv_flags[FLAG_PRESENT]) begin
      status_d = ST_NO_DRIVE;
    end else if (!drv_flags[FLAG_ATA]) begin
      status_d = ST_NON_ATA;
    end else if (end_addr > {1'b0, drv_size}) begin
      status_d = ST_RANGE;
    end else begin
      status_d = ST_ISSUED;
    end
    if (in_item_i.block_address[31:LBA28_W] != '0) begin
      mode_d = MODE_LBA48;
    end else if (drv_flags[FLAG_LBA]) begin
      mode_d = MODE_LBA28;
    end else begin
      mode_d = MODE_CHS;
    end
  end

  logic [1:0]  a_status_q, a_mode_q;
  logic        a_chan_q, a_slave_q, a_wr_q;
  logic [31:0] a_lba_q;
  logic [7:0]  a_cnt_q;

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      a_status_q <= status_d;
      a_mode_q   <= mode_d;
      a_chan_q   <= drv_flags[FLAG_CHANNEL];
      a_slave_q  <= drv_flags[FLAG_SLAVE];
      a_wr_q     <= in_item_i.opcode;
      a_lba_q    <= in_item_i.block_address;
      a_cnt_q    <= in_item_i.sector_count;
    end
  end

  // Stage B: quotient by 63 through the reciprocal
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(a_lba_q[LBA28_W-1:0]) * PROD_W'(RECIP63);

  logic [1:0]        b_status_q, b_mode_q;
  logic              b_chan_q, b_slave_q, b_wr_q;
  logic [31:0]       b_lba_q;
  logic [7:0]        b_cnt_q;
  logic [QUOT_W-1:0] b_quot_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      b_status_q <= a_status_q;
      b_mode_q   <= a_mode_q;
      b_chan_q   <= a_chan_q;
      b_slave_q  <= a_slave_q;
      b_wr_q     <= a_wr_q;
      b_lba_q    <= a_lba_q;
      b_cnt_q    <= a_cnt_q;
      b_quot_q   <= prod[RECIP_SH +: QUOT_W];
    end
  end

  // Stage C: remainder and task-file bytes
  logic [7:0] q_times63;
  logic [7:0] sect;
  out_item_t  res_d;
  out_item_t  res_q;

  always_comb begin
    // remainder stays below 63, so the low byte is enough
    q_times63 = 8'(b_quot_q) * SECTORS_PER_TRACK;
    sect      = b_lba_q[7:0] - q_times63 + 8'd1;
    res_d                = '0;
    res_d.status         = b_status_q;
    if (b_status_q == ST_ISSUED) begin
      res_d.channel_select = b_chan_q;
      res_d.address_mode   = b_mode_q;
      res_d.count_byte     = b_cnt_q;
      case (b_mode_q)
        MODE_CHS: begin
          res_d.device_select = DEVSEL_CHS | {3'd0, b_slave_q, b_quot_q[3:0]};
          res_d.addr_byte0    = sect;
          res_d.addr_byte1    = b_quot_q[11:4];
          res_d.addr_byte2    = b_quot_q[19:12];
        end
        MODE_LBA28: begin
          res_d.device_select = DEVSEL_LBA | {3'd0, b_slave_q, b_lba_q[27:24]};
          res_d.addr_byte0    = b_lba_q[7:0];
          res_d.addr_byte1    = b_lba_q[15:8];
          res_d.addr_byte2    = b_lba_q[23:16];
        end
        default: begin
          res_d.device_select = DEVSEL_LBA | {3'd0, b_slave_q, 4'd0};
          res_d.addr_byte0    = b_lba_q[7:0];
          res_d.addr_byte1    = b_lba_q[15:8];
          res_d.addr_byte2    = b_lba_q[23:16];
          res_d.addr_byte3    = b_lba_q[31:24];
        end
      endcase
      if (b_mode_q == MODE_LBA48) begin
        res_d.command_code = b_wr_q ? CMD_WRITE_EXT : CMD_READ_EXT;
        res_d.flush_code   = b_wr_q ? CMD_FLUSH_EXT : CMD_NONE;
      end else begin
        res_d.command_code = b_wr_q ? CMD_WRITE : CMD_READ;
        res_d.flush_code   = b_wr_q ? CMD_FLUSH : CMD_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vc_q;
  assign out_item_o  = res_q;

endmodule

>>> verif/atb_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the ATA task-file builder: it follows the drive table
// writes, predicts the task-file for every accepted request and compares each
// delivered result in order. Depends on atb_pkg for item structs and codes.
module atb_result_checker #(
  parameter int unsigned DRIVE_COUNT = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [atb_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [atb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  atb_pkg::in_item_t               in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  atb_pkg::out_item_t              out_item_i,
  output int unsigned                     error_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  import atb_pkg::*;

  localparam int unsigned CHS_HEADS = 16;
  localparam int unsigned DRV_W     = (DRIVE_COUNT > 1) ? $clog2(DRIVE_COUNT) : 1;

  // Local copy of the drive table
  logic [FLAGS_W-1:0] drive_flags_q;
  logic [31:0]        drive_sectors_q [DRIVE_COUNT];

  // Task-files still owed by the block, oldest first
  out_item_t taskfile_fifo [$];

  // Build the task-file that one request should produce
  function automatic out_item_t predict_taskfile(in_item_t req);
    out_item_t   res;
    int unsigned drv;
    logic [4:0]  dflags;
    logic [32:0] span_end;
    logic [31:0] lba;
    logic [31:0] rem63;
    logic [31:0] base;
    logic [31:0] cyl;
    logic [31:0] head;
    logic        is_write;
    res      = '0;
    lba      = req.block_address;
    is_write = req.opcode;
    drv      = req.drive_index;
    if (drv >= DRIVE_COUNT) begin
      res.status = ST_NO_DRIVE;
    end else begin
      dflags   = drive_flags_q[drv*FLAG_BITS +: FLAG_BITS];
      span_end = {1'b0, lba} + {25'd0, req.sector_count};
      if (!dflags[FLAG_PRESENT]) begin
        res.status = ST_NO_DRIVE;
      end else if (!dflags[FLAG_ATA]) begin
        res.status = ST_NON_ATA;
      end else if (span_end > {1'b0, drive_sectors_q[DRV_W'(drv)]}) begin
        res.status = ST_RANGE;
      end else begin
        res.status         = ST_ISSUED;
        res.channel_select = dflags[FLAG_CHANNEL];
        res.count_byte     = req.sector_count;
        head               = '0;
        if (lba >= 32'h1000_0000) begin
          res.address_mode = MODE_LBA48;
          res.addr_byte0   = lba[7:0];
          res.addr_byte1   = lba[15:8];
          res.addr_byte2   = lba[23:16];
          res.addr_byte3   = lba[31:24];
        end else if (dflags[FLAG_LBA]) begin
          res.address_mode = MODE_LBA28;
          res.addr_byte0   = lba[7:0];
          res.addr_byte1   = lba[15:8];
          res.addr_byte2   = lba[23:16];
          head             = {28'd0, lba[27:24]};
        end else begin
          // Cylinder keeps only its low 16 bits
          rem63            = lba % SECTORS_PER_TRACK;
          base             = lba - rem63;
          cyl              = base / (CHS_HEADS * SECTORS_PER_TRACK);
          head             = (base % (CHS_HEADS * SECTORS_PER_TRACK)) / SECTORS_PER_TRACK;
          res.address_mode = MODE_CHS;
          res.addr_byte0   = rem63[7:0] + 8'd1;
          res.addr_byte1   = cyl[7:0];
          res.addr_byte2   = cyl[15:8];
        end
        res.device_select = ((res.address_mode == MODE_CHS) ? DEVSEL_CHS : DEVSEL_LBA)
                            | {3'b000, dflags[FLAG_SLAVE], 4'b0000} | head[7:0];
        if (res.address_mode == MODE_LBA48) begin
          res.command_code = is_write ? CMD_WRITE_EXT : CMD_READ_EXT;
          res.flush_code   = is_write ? CMD_FLUSH_EXT : CMD_NONE;
        end else begin
          res.command_code = is_write ? CMD_WRITE : CMD_READ;
          res.flush_code   = is_write ? CMD_FLUSH : CMD_NONE;
        end
      end
    end
    return res;
  endfunction

  // Report one differing field
  task automatic compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (exp_val !== act_val) begin
      error_count_o++;
      $display("%0t: mismatch on %s: expected %02h, actual %02h", $time, name,
               exp_val, act_val);
    end
  endtask

  // Track the table, queue predictions and check results
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      drive_flags_q = '0;
      for (int d = 0; d < DRIVE_COUNT; d++) drive_sectors_q[DRV_W'(d)] = '0;
      taskfile_fifo.delete();
      error_count_o = 0;
      checked_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (taskfile_fifo.size() == 0) begin
          error_count_o++;
          $display("%0t: result %h arrived with nothing expected", $time, out_item_i);
        end else begin
          want = taskfile_fifo.pop_front();
          checked_o++;
          compare_field("status", 8'(want.status), 8'(out_item_i.status));
          compare_field("channel_select", 8'(want.channel_select),
                        8'(out_item_i.channel_select));
          compare_field("address_mode", 8'(want.address_mode), 8'(out_item_i.address_mode));
          compare_field("device_select", want.device_select, out_item_i.device_select);
          compare_field("count_byte", want.count_byte, out_item_i.count_byte);
          compare_field("addr_byte0", want.addr_byte0, out_item_i.addr_byte0);
          compare_field("addr_byte1", want.addr_byte1, out_item_i.addr_byte1);
          compare_field("addr_byte2", want.addr_byte2, out_item_i.addr_byte2);
          compare_field("addr_byte3", want.addr_byte3, out_item_i.addr_byte3);
          compare_field("command_code", want.command_code, out_item_i.command_code);
          compare_field("flush_code", want.flush_code, out_item_i.flush_code);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        taskfile_fifo.push_back(predict_taskfile(in_item_i));
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_DRIVE_FLAGS) begin
          drive_flags_q = cfg_data_i[FLAGS_W-1:0];
        end else if (cfg_index_i >= REG_SECTORS0 &&
                     cfg_index_i < REG_SECTORS0 + DRIVE_COUNT) begin
          drive_sectors_q[DRV_W'(cfg_index_i - REG_SECTORS0)] = cfg_data_i;
        end
      end
    end
  end

  assign pending_o = taskfile_fifo.size();

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the ATA task-file builder testbench: clock, reset, drive table
// settings and request stimulus. Depends on atb_pkg, the block and atb_result_checker.
module tb_top;
  import atb_pkg::*;

  localparam int unsigned DRIVES        = 4;
  localparam int unsigned PIPE_LATENCY  = 3;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 275;
  localparam int unsigned IDLE_PERCENT  = 28;
  localparam logic        OP_READ       = 1'b0;
  localparam logic        OP_WRITE      = 1'b1;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  in_item_t               in_item_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  out_item_t              out_item_o;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned sent_count;
  int unsigned table_count;
  int unsigned hold_req_count;
  int unsigned hold_served;
  bit          no_idle;
  logic [31:0] sectors_shadow [DRIVES];

  ata_taskfile_builder_unit #(
    .DRIVE_COUNT(DRIVES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  atb_result_checker #(
    .DRIVE_COUNT(DRIVES)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .error_count_o(error_count),
    .pending_o    (pending_count),
    .checked_o    (checked_count)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Give up after a generous time
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req_count != hold_served) begin
        hold_served = hold_req_count;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  function automatic in_item_t make_req(logic op, logic [7:0] drv, logic [31:0] lba,
                                        logic [7:0] cnt);
    in_item_t req;
    req.opcode        = op;
    req.drive_index   = drv;
    req.block_address = lba;
    req.sector_count  = cnt;
    return req;
  endfunction

  // Offer one item, idling at random first; returns after acceptance
  task automatic send_request(in_item_t req);
    bit taken;
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sent_count++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // Present one register write for a single edge; the caller drops the enable
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // Load the whole drive table and keep the sizes for stimulus shaping
  task automatic load_drive_table(logic [FLAGS_W-1:0] flags, logic [31:0] s0,
                                  logic [31:0] s1, logic [31:0] s2, logic [31:0] s3);
    write_reg(REG_DRIVE_FLAGS, {12'd0, flags});
    write_reg(REG_SECTORS0 + 3'd0, s0);
    write_reg(REG_SECTORS0 + 3'd1, s1);
    write_reg(REG_SECTORS0 + 3'd2, s2);
    write_reg(REG_SECTORS0 + 3'd3, s3);
    cfg_we_i <= 1'b0;
    sectors_shadow[0] = s0;
    sectors_shadow[1] = s1;
    sectors_shadow[2] = s2;
    sectors_shadow[3] = s3;
    table_count++;
  endtask

  function automatic logic [31:0] pick_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25)      return 32'hFFFF_FFFF;
    else if (pick < 50) return $urandom;
    else if (pick < 70) return 32'h1000_0000 + $urandom_range(512);
    else if (pick < 92) return $urandom_range(5000);
    else                return 32'd0;
  endfunction

  // Mostly present ATA drives, the rest random flag groups
  function automatic logic [FLAGS_W-1:0] pick_flags();
    logic [FLAGS_W-1:0] flags;
    logic [4:0]         grp;
    flags = '0;
    for (int d = 0; d < DRIVES; d++) begin
      grp = 5'($urandom_range(31));
      if ($urandom_range(99) < 80) grp |= 5'b00011;
      flags[d*FLAG_BITS +: FLAG_BITS] = grp;
    end
    return flags;
  endfunction

  // Random request: mostly a valid drive, often with an address near an interesting edge
  function automatic in_item_t make_random_request();
    in_item_t    req;
    int unsigned pick;
    logic [31:0] size;
    req.opcode        = 1'($urandom_range(1));
    req.drive_index   = 8'($urandom_range(DRIVES - 1));
    req.sector_count  = 8'($urandom_range(255));
    if ($urandom_range(99) < 10) req.sector_count = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    size = sectors_shadow[req.drive_index[1:0]];
    pick = $urandom_range(99);
    if (pick < 8) begin
      req = in_item_t'({$urandom, $urandom});
    end else if (pick < 35) begin
      req.block_address = $urandom_range(32'h0FFF_FFFF);
    end else if (pick < 58) begin
      req.block_address = size - req.sector_count + $urandom_range(4) - 2;
    end else if (pick < 72) begin
      req.block_address = 32'h1000_0000 + $urandom_range(16) - 8;
    end else if (pick < 88) begin
      req.block_address = $urandom_range(size);
    end else begin
      req.block_address = $urandom;
    end
    return req;
  endfunction

  // Stimulus
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    no_idle        = 1'b0;
    hold_req_count = 0;
    sent_count     = 0;
    table_count    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: drive 0 LBA master, drive 1 CHS slave on channel 1,
    // drive 2 present but not ATA, drive 3 absent
    load_drive_table(20'h0_0767, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100, 32'd0);
    send_request(make_req(OP_READ,  8'd0, 32'h0000_0000, 8'd0));
    send_request(make_req(OP_WRITE, 8'd0, 32'h0FFF_FFFF, 8'd0));
    send_request(make_req(OP_READ,  8'd0, 32'h1000_0000, 8'd255));
    send_request(make_req(OP_WRITE, 8'd0, 32'hFFFF_FF00, 8'd255));
    send_request(make_req(OP_WRITE, 8'd0, 32'hFFFF_FFFF, 8'd1));
    send_request(make_req(OP_READ,  8'd0, 32'hFFFF_FFFF, 8'd0));
    send_request(make_req(OP_READ,  8'd0, 32'hFFFF_FF38, 8'd200));
    send_request(make_req(OP_READ,  8'd1, 32'd0, 8'd1));
    send_request(make_req(OP_WRITE, 8'd1, 32'd62, 8'd7));
    send_request(make_req(OP_READ,  8'd1, 32'd63, 8'd8));
    send_request(make_req(OP_READ,  8'd1, 32'd1007, 8'd9));
    send_request(make_req(OP_WRITE, 8'd1, 32'd1008, 8'd10));
    // Cylinder wider than 16 bits gets cut
    send_request(make_req(OP_WRITE, 8'd1, 32'h0FFF_FFFF, 8'd255));
    send_request(make_req(OP_READ,  8'd1, 32'd66060288, 8'd3));
    // Large start on a drive without LBA still goes LBA48
    send_request(make_req(OP_WRITE, 8'd1, 32'h1000_0000, 8'd4));
    send_request(make_req(OP_READ,  8'd2, 32'd0, 8'd1));
    send_request(make_req(OP_WRITE, 8'd2, 32'hFFFF_FFFF, 8'd255));
    send_request(make_req(OP_READ,  8'd3, 32'd0, 8'd0));
    send_request(make_req(OP_READ,  8'd4, 32'd0, 8'd0));
    send_request(make_req(OP_WRITE, 8'd255, 32'hFFFF_FFFF, 8'd255));
    send_request(make_req(OP_READ,  8'd128, 32'h5555_5555, 8'd85));
    drain_results();

    // Random phases over several drive tables, extremes first
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)      load_drive_table(20'hF_FFFF, '1, '1, '1, '1);
      else if (p == 1) load_drive_table(20'h0_0000, '0, '0, '0, '0);
      else             load_drive_table(pick_flags(), pick_size(), pick_size(),
                                        pick_size(), pick_size());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 100) hold_req_count <= hold_req_count + 1;
        if (p == 3) no_idle = (n >= 50 && n < 150);
        send_request(make_random_request());
      end
      drain_results();
    end

    $display("Summary: %0d requests over %0d drive tables, %0d results checked.",
             sent_count, table_count, checked_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> ata_taskfile_builder_unit.f
sv/atb_pkg.sv
sv/ata_taskfile_builder_unit.sv
verif/atb_result_checker.sv
verif/tb_top.sv
